// ----- hdl/fct_pkg.sv -----
// Shared types and constants of the frustum cull test block.
package fct_pkg;

    // Query kinds; any other code is taken as a point query
    localparam logic [1:0] OP_BOX    = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;

    // Visibility codes
    localparam logic [1:0] VIS_OUTSIDE = 2'd0;
    localparam logic [1:0] VIS_PARTIAL = 2'd1;
    localparam logic [1:0] VIS_FULL    = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int PLANE_W     = 64;

    // Plane packing: four signed 16-bit values
    localparam int COMP_W = 16;
    localparam int HALF_W = 15;

    // Q1.14 times Q8.8 leaves 22 fraction bits; offsets and radius align by 14
    localparam int FRAC_SH = 14;

    // Datapath widths, sized to the exact ranges of the products and sums
    localparam int PC_W  = 32;  // signed normal * signed center
    localparam int MAG_W = 17;  // |normal|, up to 2^15
    localparam int PH_W  = 30;  // |normal| * half extent
    localparam int DC_W  = 33;  // signed distance of the center
    localparam int T_W   = 32;  // box spread or scaled radius
    localparam int SUM_W = 34;  // distance plus or minus spread

    typedef struct packed {
        logic outside;
        logic partial;
    } t_flags;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [COMP_W-1:0] cx;
        logic signed [COMP_W-1:0] cy;
        logic signed [COMP_W-1:0] cz;
        logic [HALF_W-1:0]        hx;
        logic [HALF_W-1:0]        hy;
        logic [HALF_W-1:0]        hz;
        logic [HALF_W-1:0]        radius;
        t_flags                   flags;
    } t_word;

endpackage

// ----- hdl/fct_in_if.sv -----
// Query channel: valid, ready and the query fields.
interface fct_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        operation;
    logic signed [fct_pkg::COMP_W-1:0] center_x;
    logic signed [fct_pkg::COMP_W-1:0] center_y;
    logic signed [fct_pkg::COMP_W-1:0] center_z;
    logic [fct_pkg::HALF_W-1:0]        half_x;
    logic [fct_pkg::HALF_W-1:0]        half_y;
    logic [fct_pkg::HALF_W-1:0]        half_z;
    logic [fct_pkg::HALF_W-1:0]        radius;

    modport source (
        output valid, operation, center_x, center_y, center_z,
               half_x, half_y, half_z, radius,
        input  ready
    );
    modport sink (
        input  valid, operation, center_x, center_y, center_z,
               half_x, half_y, half_z, radius,
        output ready
    );
endinterface

// ----- hdl/fct_out_if.sv -----
// Result channel: valid, ready and the visibility code.
interface fct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] visibility;

    modport source (output valid, visibility, input ready);
    modport sink   (input valid, visibility, output ready);
endinterface

// ----- hdl/fct_plane_regs.sv -----
// Plane configuration registers, one 64-bit word per plane.
module fct_plane_regs #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [fct_pkg::CFG_INDEX_W-1:0]                 i_cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]                     i_cfg_data,
    output logic [PLANE_COUNT-1:0][fct_pkg::PLANE_W-1:0]    o_planes
);

    logic [PLANE_COUNT-1:0][fct_pkg::PLANE_W-1:0] r_planes;

    // Drop writes to indexes without a plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg_we) begin
            for (int k = 0; k < PLANE_COUNT; k++) begin
                if (i_cfg_index == fct_pkg::CFG_INDEX_W'(k)) begin
                    r_planes[k] <= i_cfg_data;
                end
            end
        end
    end

    assign o_planes = r_planes;

endmodule

// ----- hdl/fct_cell.sv -----
// One plane cell: three register stages that test a query word against one plane.
module fct_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [fct_pkg::PLANE_W-1:0]  i_plane,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  fct_pkg::t_word               i_word,
    output logic                         o_valid,
    input  logic                         i_ready,
    output fct_pkg::t_word               o_word
);

    // Plane fields
    logic signed [fct_pkg::COMP_W-1:0] nx, ny, nz, pd;
    assign nx = i_plane[15:0];
    assign ny = i_plane[31:16];
    assign nz = i_plane[47:32];
    assign pd = i_plane[63:48];

    // Stage enables; a stage advances when empty or when its successor advances
    logic en1, en2, en3;
    logic r1_v, r2_v, r3_v;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;
    assign o_valid = r3_v;

    // Stage 1: products
    fct_pkg::t_word                   r1_word;
    logic signed [fct_pkg::PC_W-1:0]  r1_pc [3];
    logic signed [fct_pkg::PC_W-1:0]  n1_pc [3];
    logic [fct_pkg::PH_W-1:0]         r1_ph [3];
    logic [fct_pkg::PH_W-1:0]         n1_ph [3];
    logic [fct_pkg::MAG_W-1:0]        mag_x, mag_y, mag_z;

    function automatic logic [fct_pkg::MAG_W-1:0] f_mag(
        input logic signed [fct_pkg::COMP_W-1:0] v
    );
        logic [fct_pkg::MAG_W-1:0] ext;
        ext = {v[fct_pkg::COMP_W-1], v};
        return v[fct_pkg::COMP_W-1] ? (~ext + 1'b1) : ext;
    endfunction

    always_comb begin
        mag_x    = f_mag(nx);
        mag_y    = f_mag(ny);
        mag_z    = f_mag(nz);
        n1_pc[0] = fct_pkg::PC_W'(nx * i_word.cx);
        n1_pc[1] = fct_pkg::PC_W'(ny * i_word.cy);
        n1_pc[2] = fct_pkg::PC_W'(nz * i_word.cz);
        // |n| * h is the far-vertex term of the box on each axis
        n1_ph[0] = fct_pkg::PH_W'(mag_x * i_word.hx);
        n1_ph[1] = fct_pkg::PH_W'(mag_y * i_word.hy);
        n1_ph[2] = fct_pkg::PH_W'(mag_z * i_word.hz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_word <= i_word;
            r1_pc   <= n1_pc;
            r1_ph   <= n1_ph;
        end
    end

    // Stage 2: center distance and spread
    fct_pkg::t_word                  r2_word;
    logic signed [fct_pkg::DC_W-1:0] r2_dc, n2_dc;
    logic [fct_pkg::T_W-1:0]         r2_t, n2_t;

    always_comb begin
        n2_dc = fct_pkg::DC_W'(r1_pc[0]) + fct_pkg::DC_W'(r1_pc[1])
              + fct_pkg::DC_W'(r1_pc[2]) + (fct_pkg::DC_W'(pd) <<< fct_pkg::FRAC_SH);
        case (r1_word.op)
            fct_pkg::OP_BOX: begin
                n2_t = fct_pkg::T_W'(r1_ph[0]) + fct_pkg::T_W'(r1_ph[1])
                     + fct_pkg::T_W'(r1_ph[2]);
            end
            fct_pkg::OP_SPHERE: begin
                n2_t = fct_pkg::T_W'(r1_word.radius) << fct_pkg::FRAC_SH;
            end
            default: begin
                n2_t = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_word <= r1_word;
            r2_dc   <= n2_dc;
            r2_t    <= n2_t;
        end
    end

    // Stage 3: far side below zero culls, near side below zero marks partial
    fct_pkg::t_word            r3_word, n3_word;
    logic [fct_pkg::SUM_W-1:0] far_sum, near_sum;

    always_comb begin
        far_sum  = {r2_dc[fct_pkg::DC_W-1], r2_dc} + {2'b00, r2_t};
        near_sum = {r2_dc[fct_pkg::DC_W-1], r2_dc} - {2'b00, r2_t};
        n3_word  = r2_word;
        n3_word.flags.outside = r2_word.flags.outside || far_sum[fct_pkg::SUM_W-1];
        n3_word.flags.partial = r2_word.flags.partial || near_sum[fct_pkg::SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_word <= n3_word;
        end
    end

    assign o_word = r3_word;

    // An outside mark is never lost on its way through the cell
    a_outside_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && en3 && r2_word.flags.outside) |=> r3_word.flags.outside)
        else $error("outside flag dropped in plane cell");

    // Point queries carry no spread
    a_point_no_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && r2_word.op != fct_pkg::OP_BOX && r2_word.op != fct_pkg::OP_SPHERE)
        |-> (r2_t == '0))
        else $error("spread set for a point query");

    // A stalled word holds in the last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !i_ready) |=> (r3_v && $stable(r3_word)))
        else $error("stalled word changed in plane cell");

    // A full pipe with a stalled output takes no new word
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r2_v && r3_v && !i_ready) |-> !o_ready)
        else $error("plane cell accepted a word while full");

endmodule

// ----- hdl/frustum_cull_test_unit.sv -----
// Top level of the frustum cull test: plane registers and a chain of plane cells.
//
// Classifies a stream of queries (box, sphere or point) against up to six
// frustum planes held in configuration registers, in the order left, right,
// bottom, top, near, far. Each plane register packs normal x, y, z (signed
// Q1.14) in bits 47:0 and the offset (signed Q8.8) in bits 63:48; write
// them through i_cfg_we / i_cfg_index / i_cfg_data while no query is in
// flight. Writes to indexes without a plane are dropped. The query word
// enters a chain of PLANE_COUNT identical cells; each cell owns one plane
// and computes, exactly, the center distance n.c + d and a spread (the
// box's |n|.h, the sphere's radius, zero for a point), then marks the word
// outside when distance plus spread is negative and partial when distance
// minus spread is negative. The last cell's marks give the visibility:
// 0 outside, 1 partial, 2 full. Throughput is one query per cycle while
// the result side is ready; each cell has three register stages
// (products, sums, compare). Each stage advances when it is empty or its
// successor moves, so bubbles close up and queries keep entering while a
// finished result waits at the output. Code 3 of the operation field is
// taken as a point query.
module frustum_cull_test_unit #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fct_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]        i_cfg_data,
    fct_in_if.sink                             i_query,
    fct_out_if.source                          o_result
);

    logic [PLANE_COUNT-1:0][fct_pkg::PLANE_W-1:0] planes;

    fct_plane_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (planes)
    );

    // Chain links: link k feeds cell k, link PLANE_COUNT is the result
    logic           link_valid [PLANE_COUNT+1];
    logic           link_ready [PLANE_COUNT+1];
    fct_pkg::t_word link_word  [PLANE_COUNT+1];

    // Pack the incoming word with clear marks
    always_comb begin
        link_word[0].op            = i_query.operation;
        link_word[0].cx            = i_query.center_x;
        link_word[0].cy            = i_query.center_y;
        link_word[0].cz            = i_query.center_z;
        link_word[0].hx            = i_query.half_x;
        link_word[0].hy            = i_query.half_y;
        link_word[0].hz            = i_query.half_z;
        link_word[0].radius        = i_query.radius;
        link_word[0].flags.outside = 1'b0;
        link_word[0].flags.partial = 1'b0;
    end
    assign link_valid[0]  = i_query.valid;
    assign i_query.ready  = link_ready[0];

    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
        fct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (planes[k]),
            .i_valid (link_valid[k]),
            .o_ready (link_ready[k]),
            .i_word  (link_word[k]),
            .o_valid (link_valid[k+1]),
            .i_ready (link_ready[k+1]),
            .o_word  (link_word[k+1])
        );
    end

    // Outside wins over partial; no marks means fully inside
    always_comb begin
        if (link_word[PLANE_COUNT].flags.outside) begin
            o_result.visibility = fct_pkg::VIS_OUTSIDE;
        end else if (link_word[PLANE_COUNT].flags.partial) begin
            o_result.visibility = fct_pkg::VIS_PARTIAL;
        end else begin
            o_result.visibility = fct_pkg::VIS_FULL;
        end
    end
    assign o_result.valid         = link_valid[PLANE_COUNT];
    assign link_ready[PLANE_COUNT] = o_result.ready;

endmodule

// ----- tb/tb_frustum_cull_test_unit.sv -----
// Testbench for frustum_cull_test_unit: random and directed queries, exact predictor.
`timescale 1ns / 1ps

module tb_frustum_cull_test_unit;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_REGS  = 6;

    // Register indexes of the configuration port; six and seven hold no plane
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_LEFT    = 3'd0;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_RIGHT   = 3'd1;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_BOTTOM  = 3'd2;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_TOP     = 3'd3;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_NEAR    = 3'd4;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_FAR     = 3'd5;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] IDX_SPARE_B = 3'd7;
    localparam logic [fct_pkg::CFG_INDEX_W-1:0] PLANE_ORDER [PLANE_REGS] =
        '{IDX_LEFT, IDX_RIGHT, IDX_BOTTOM, IDX_TOP, IDX_NEAR, IDX_FAR};

    // Operation code with no query of its own; the block takes it as a point
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Fixed-point scales: Q1.14 unit normal, Q8.8 unit length, 22-bit alignment
    localparam int     UNIT_NORMAL  = 1 << fct_pkg::FRAC_SH;
    localparam int     Q88_ONE      = 256;
    localparam longint FRAC_ONE     = longint'(1) << fct_pkg::FRAC_SH;
    localparam int     CUBE_OFFSET  = 100 * Q88_ONE;
    localparam int     TIGHT_OFFSET = 10 * Q88_ONE;

    localparam int LATENCY     = 3 * PLANE_COUNT;
    localparam int LONG_HOLD   = 150;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {
        SET_CUBE, SET_TIGHT, SET_TILTED, SET_ZERO,
        SET_EXTREME, SET_CULL_ALL, SET_RANDOM, SET_OFFSET_ONLY
    } t_plane_set;

    typedef struct packed {
        logic [1:0]                        op;
        logic signed [fct_pkg::COMP_W-1:0] cx;
        logic signed [fct_pkg::COMP_W-1:0] cy;
        logic signed [fct_pkg::COMP_W-1:0] cz;
        logic [fct_pkg::HALF_W-1:0]        hx;
        logic [fct_pkg::HALF_W-1:0]        hy;
        logic [fct_pkg::HALF_W-1:0]        hz;
        logic [fct_pkg::HALF_W-1:0]        radius;
    } t_cull_query;

    // Plane copy, expected visibility codes and the error count
    class t_cull_scoreboard;
        logic [fct_pkg::PLANE_W-1:0] planes [PLANE_REGS];
        logic [1:0]                  pending_vis [$];
        int                          errors;

        function new();
            foreach (planes[i]) planes[i] = '0;
            errors = 0;
        endfunction

        function void load_plane(logic [fct_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [fct_pkg::PLANE_W-1:0] word);
            if (idx < PLANE_REGS) planes[idx] = word;
        endfunction

        function longint field_at(logic [fct_pkg::PLANE_W-1:0] word, int k);
            logic signed [fct_pkg::COMP_W-1:0] f;
            f = word[fct_pkg::COMP_W*k +: fct_pkg::COMP_W];
            return longint'(f);
        endfunction

        // Exact signed distances with 22 fraction bits; zero counts as inside
        function logic [1:0] classify(t_cull_query q);
            longint n [3];
            longint c [3];
            longint h [3];
            longint d, rad, far_d, near_d, ctr_d, s;
            bit     outside, partial;
            outside = 0;
            partial = 0;
            c[0] = longint'($signed(q.cx));
            c[1] = longint'($signed(q.cy));
            c[2] = longint'($signed(q.cz));
            h[0] = longint'(q.hx);
            h[1] = longint'(q.hy);
            h[2] = longint'(q.hz);
            rad  = longint'(q.radius) * FRAC_ONE;
            for (int i = 0; i < PLANE_COUNT && i < PLANE_REGS; i++) begin
                for (int k = 0; k < 3; k++) n[k] = field_at(planes[i], k);
                d = field_at(planes[i], 3) * FRAC_ONE;
                if (q.op == fct_pkg::OP_BOX) begin
                    // far vertex leans along the normal, near vertex against it
                    far_d  = d;
                    near_d = d;
                    for (int k = 0; k < 3; k++) begin
                        s = (n[k] >= 0) ? h[k] : -h[k];
                        far_d  += n[k] * (c[k] + s);
                        near_d += n[k] * (c[k] - s);
                    end
                    if (far_d < 0) outside = 1;
                    else if (near_d < 0) partial = 1;
                end else begin
                    ctr_d = d + n[0] * c[0] + n[1] * c[1] + n[2] * c[2];
                    if (q.op == fct_pkg::OP_SPHERE) begin
                        if (ctr_d < -rad) outside = 1;
                        else if (ctr_d < rad) partial = 1;
                    end else if (ctr_d < 0) begin
                        outside = 1;
                    end
                end
            end
            return outside ? fct_pkg::VIS_OUTSIDE
                           : (partial ? fct_pkg::VIS_PARTIAL : fct_pkg::VIS_FULL);
        endfunction

        function void note_query(t_cull_query q);
            pending_vis.push_back(classify(q));
        endfunction

        function int pending();
            return pending_vis.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] check failed: %s", $time, msg);
        endtask

        task check_result(logic [1:0] vis);
            logic [1:0] want;
            if (pending_vis.size() == 0) begin
                report($sformatf("visibility %0d with no query waiting", vis));
            end else begin
                want = pending_vis.pop_front();
                if (vis !== want) report($sformatf("visibility %0d, expected %0d", vis, want));
            end
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [fct_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [fct_pkg::PLANE_W-1:0]     i_cfg_data;

    fct_in_if  q_if ();
    fct_out_if r_if ();

    t_cull_scoreboard sb = new();

    frustum_cull_test_unit #(
        .PLANE_COUNT (PLANE_COUNT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_query     (q_if),
        .o_result    (r_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [fct_pkg::PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    // Axis-aligned cube of half side d around the origin, normals pointing inward
    function automatic logic [fct_pkg::PLANE_W-1:0] cube_plane(
        logic [fct_pkg::CFG_INDEX_W-1:0] idx, int d
    );
        case (idx)
            IDX_LEFT:   return pack_plane(UNIT_NORMAL, 0, 0, d);
            IDX_RIGHT:  return pack_plane(-UNIT_NORMAL, 0, 0, d);
            IDX_BOTTOM: return pack_plane(0, UNIT_NORMAL, 0, d);
            IDX_TOP:    return pack_plane(0, -UNIT_NORMAL, 0, d);
            IDX_NEAR:   return pack_plane(0, 0, UNIT_NORMAL, d);
            default:    return pack_plane(0, 0, -UNIT_NORMAL, d);
        endcase
    endfunction

    function automatic int random_normal();
        return int'($urandom_range(0, 2 * UNIT_NORMAL)) - UNIT_NORMAL;
    endfunction

    // A quarter of the values span the whole field; the rest stay near the planes
    function automatic logic [fct_pkg::COMP_W-1:0] random_coord(int span);
        int v;
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = int'($urandom_range(0, 2 * span)) - span;
        return v[fct_pkg::COMP_W-1:0];
    endfunction

    function automatic logic [fct_pkg::HALF_W-1:0] random_half(int span);
        int v;
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = $urandom_range(0, span / 2);
        return v[fct_pkg::HALF_W-1:0];
    endfunction

    function automatic t_cull_query random_query(int span);
        t_cull_query q;
        int          pick;
        pick = $urandom_range(0, 7);
        q.op = (pick < 3) ? fct_pkg::OP_BOX :
               (pick < 5) ? fct_pkg::OP_SPHERE :
               (pick < 7) ? fct_pkg::OP_POINT : OP_RESERVED;
        q.cx = random_coord(span);
        q.cy = random_coord(span);
        q.cz = random_coord(span);
        q.hx = random_half(span);
        q.hy = random_half(span);
        q.hz = random_half(span);
        q.radius = random_half(span);
        return q;
    endfunction

    function automatic t_cull_query mk_query(logic [1:0] op, int cx, int cy, int cz,
                                             int hx, int hy, int hz, int r);
        t_cull_query q;
        q.op = op;
        q.cx = cx[fct_pkg::COMP_W-1:0];
        q.cy = cy[fct_pkg::COMP_W-1:0];
        q.cz = cz[fct_pkg::COMP_W-1:0];
        q.hx = hx[fct_pkg::HALF_W-1:0];
        q.hy = hy[fct_pkg::HALF_W-1:0];
        q.hz = hz[fct_pkg::HALF_W-1:0];
        q.radius = r[fct_pkg::HALF_W-1:0];
        return q;
    endfunction

    // Offer one query word, optionally after an idle gap, and hold it until taken
    task automatic send_query(t_cull_query q, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            q_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        q_if.valid     <= 1'b1;
        q_if.operation <= q.op;
        q_if.center_x  <= q.cx;
        q_if.center_y  <= q.cy;
        q_if.center_z  <= q.cz;
        q_if.half_x    <= q.hx;
        q_if.half_y    <= q.hy;
        q_if.half_z    <= q.hz;
        q_if.radius    <= q.radius;
        do @(posedge i_clk); while (!q_if.ready);
        sb.note_query(q);
    endtask

    // Drop valid and hold until every expected word has come back
    task automatic drain();
        q_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write all six planes for one setting, back to back; the block is idle here
    task automatic program_planes(t_plane_set setting);
        logic [fct_pkg::PLANE_W-1:0] word;
        for (int i = 0; i < PLANE_REGS; i++) begin
            case (setting)
                SET_CUBE:  word = cube_plane(PLANE_ORDER[i], CUBE_OFFSET);
                SET_TIGHT: word = cube_plane(PLANE_ORDER[i], TIGHT_OFFSET);
                SET_TILTED: begin
                    word = pack_plane(random_normal(), random_normal(), random_normal(),
                                      $urandom_range(0, 32767));
                end
                SET_ZERO: word = '0;
                SET_EXTREME: begin
                    for (int k = 0; k < 4; k++) begin
                        case ($urandom_range(0, 3))
                            0:       word[fct_pkg::COMP_W*k +: fct_pkg::COMP_W] = 16'h8000;
                            1:       word[fct_pkg::COMP_W*k +: fct_pkg::COMP_W] = 16'h7FFF;
                            2:       word[fct_pkg::COMP_W*k +: fct_pkg::COMP_W] = 16'h0000;
                            default: word[fct_pkg::COMP_W*k +: fct_pkg::COMP_W] = 16'hFFFF;
                        endcase
                    end
                end
                SET_CULL_ALL: begin
                    // zero normal, d < 0: culls boxes, points, spheres with r < -d
                    if (PLANE_ORDER[i] == IDX_FAR)
                        word = pack_plane(0, 0, 0, -int'($urandom_range(1, 32768)));
                    else
                        word = cube_plane(PLANE_ORDER[i], CUBE_OFFSET);
                end
                SET_RANDOM: word = {$urandom, $urandom};
                default:    word = pack_plane(0, 0, 0, $urandom_range(0, 32767));
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= PLANE_ORDER[i];
            i_cfg_data  <= word;
            sb.load_plane(PLANE_ORDER[i], word);
            @(posedge i_clk);
        end
        // Writes past the last plane must leave the planes alone
        if (setting == SET_ZERO) begin
            i_cfg_index <= IDX_SPARE_A;
            i_cfg_data  <= {$urandom, $urandom};
            @(posedge i_clk);
            i_cfg_index <= IDX_SPARE_B;
            i_cfg_data  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(t_plane_set setting, int items, int span, bit idle);
        drain();
        program_planes(setting);
        repeat (items) send_query(random_query(span), idle);
    endtask

    // Result side: random stalls, stall-free stretches, and two long hold-offs
    // that let the pipeline fill and push back on the query side
    initial begin : result_sink
        int taken;
        int stall;
        taken = 0;
        r_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == 300 || taken == 1000) stall = LONG_HOLD;
            else if ((taken / 128) % 3 == 1) stall = 0;
            else stall = $urandom_range(0, 9);
            if (stall > 0) begin
                r_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            r_if.ready <= 1'b1;
            do @(posedge i_clk); while (!r_if.valid);
            sb.check_result(r_if.visibility);
            taken++;
        end
    end

    // Watchdog: a hung handshake or a lost word ends here
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("frustum_cull_test_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_cull_query directed [$];
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= IDX_LEFT;
        i_cfg_data     <= '0;
        q_if.valid     <= 1'b0;
        q_if.operation <= fct_pkg::OP_BOX;
        q_if.center_x  <= '0;
        q_if.center_y  <= '0;
        q_if.center_z  <= '0;
        q_if.half_x    <= '0;
        q_if.half_y    <= '0;
        q_if.half_z    <= '0;
        q_if.radius    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words against the cube of half side 100.0
        directed.push_back(mk_query(fct_pkg::OP_BOX, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_BOX, 0, 0, 0, 32767, 32767, 32767, 0));
        directed.push_back(mk_query(fct_pkg::OP_BOX, -32768, -32768, -32768, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_BOX, 32767, 32767, 32767,
                                    32767, 32767, 32767, 0));
        // box touching the left plane: zero distance counts as inside
        directed.push_back(mk_query(fct_pkg::OP_BOX, -CUBE_OFFSET, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_BOX, -CUBE_OFFSET - Q88_ONE, 0, 0,
                                    Q88_ONE, 0, 0, 0));
        // radius is ignored by a box
        directed.push_back(mk_query(fct_pkg::OP_BOX, 0, 0, 0, 0, 0, 0, 32767));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, -CUBE_OFFSET, 0, 0, 0, 0, 0, 0));
        // sphere distance exactly minus the radius: partial, one step farther: outside
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, -CUBE_OFFSET - Q88_ONE, 0, 0,
                                    0, 0, 0, Q88_ONE));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, -CUBE_OFFSET - Q88_ONE - 1, 0, 0,
                                    0, 0, 0, Q88_ONE));
        directed.push_back(mk_query(fct_pkg::OP_SPHERE, 0, 0, 0, 32767, 32767, 32767, 0));
        directed.push_back(mk_query(fct_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_POINT, 0, 0, -CUBE_OFFSET, 0, 0, 0, 0));
        directed.push_back(mk_query(fct_pkg::OP_POINT, 0, 0, -CUBE_OFFSET - 1, 0, 0, 0, 0));
        // half extents and radius are ignored by a point
        directed.push_back(mk_query(fct_pkg::OP_POINT, 0, 0, 0, 32767, 32767, 32767, 32767));
        // reserved code behaves as a point, never partial
        directed.push_back(mk_query(OP_RESERVED, 0, 0, 0, 32767, 32767, 32767, 32767));
        directed.push_back(mk_query(OP_RESERVED, -32768, 0, 0, 0, 0, 0, 32767));

        // Reset planes first: all zero, so no plane rejects anything
        repeat (40) send_query(random_query(32767), 1'b1);
        drain();
        program_planes(SET_CUBE);
        foreach (directed[i]) send_query(directed[i], 1'b1);

        // Random phases across plane settings; some with the sender never idling
        run_phase(SET_CUBE,        200, 30000, 1'b1);
        run_phase(SET_TILTED,      200,  8000, 1'b0);
        run_phase(SET_ZERO,        120, 32767, 1'b1);
        run_phase(SET_EXTREME,     200, 32767, 1'b1);
        run_phase(SET_CULL_ALL,     60, 20000, 1'b0);
        run_phase(SET_RANDOM,      200, 32767, 1'b1);
        run_phase(SET_OFFSET_ONLY, 200, 32767, 1'b0);
        run_phase(SET_TIGHT,       260,  4000, 1'b1);
        drain();

        // Let any stray word surface before the verdict
        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("frustum_cull_test_unit: match");
        end else begin
            $display("frustum_cull_test_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fct_pkg.sv
hdl/fct_in_if.sv
hdl/fct_out_if.sv
hdl/fct_plane_regs.sv
hdl/fct_cell.sv
hdl/frustum_cull_test_unit.sv
tb/tb_frustum_cull_test_unit.sv
